/* hw/rtl/rsa_pkg.sv */
// Shared constants and types for the RSA private exponent block.
package rsa_pkg;
    localparam int PRIME_BITS_DEF = 18;
    localparam int IN_BITS = 18;
    localparam int KEY_BITS = 36;
    localparam int CNT_BITS = 6;

    typedef logic [KEY_BITS-1:0] key_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL,
        CMD_DIV_START,
        CMD_DIV_STEP,
        CMD_EUCLID,
        CMD_FIX
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t code;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic r1_zero;
        logic m_zero;
    } dp_status_t;
endpackage

/* hw/rtl/rsa_if.sv */
// Valid/ready channel interfaces for input and result words.
interface rsa_in_if;
    logic                 valid;
    logic                 ready;
    logic [17:0]          prime_p;
    logic [17:0]          prime_q;
    logic [35:0]          public_exp;
    modport source (output valid, prime_p, prime_q, public_exp, input ready);
    modport sink (input valid, prime_p, prime_q, public_exp, output ready);
endinterface

interface rsa_out_if;
    logic        valid;
    logic        ready;
    logic [35:0] modulus_n;
    logic [35:0] totient_m;
    logic [35:0] private_exp;
    logic        key_valid;
    modport source (output valid, modulus_n, totient_m, private_exp, key_valid,
                    input ready);
    modport sink (input valid, modulus_n, totient_m, private_exp, key_valid,
                  output ready);
endinterface

/* hw/rtl/rsa_datapath.sv */
// Datapath: multiplier, serial divider and Euclid registers.
module rsa_datapath #(
    parameter int PRIME_BITS = rsa_pkg::PRIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rsa_pkg::dp_cmd_t     cmd,
    input  logic [17:0]          prime_p,
    input  logic [17:0]          prime_q,
    input  logic [35:0]          public_exp,
    output rsa_pkg::dp_status_t  status,
    output rsa_pkg::key_t        n_out,
    output rsa_pkg::key_t        m_out,
    output rsa_pkg::key_t        d_out,
    output logic                 ok_out
);
    import rsa_pkg::*;

    localparam int PB = (PRIME_BITS < IN_BITS) ? PRIME_BITS : IN_BITS;

    logic [IN_BITS-1:0] p_reg, q_reg;
    key_t n_reg, m_reg, d_reg;
    logic ok_reg;
    logic mstep_reg;
    // Euclid state
    key_t r0_reg, r1_reg, mag0_reg, mag1_reg;
    logic neg0_reg, neg1_reg;
    // divider: dividend, divisor, remainder; acc builds quotient * mag1
    key_t dvd_reg, dvs_reg, rem_reg, acc_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic div_done_reg;
    logic fix_reg;

    logic [IN_BITS-1:0] pm, qm;
    logic [IN_BITS-1:0] pm1, qm1;
    logic [2*IN_BITS-1:0] prod;
    logic [KEY_BITS:0] trial;

    always_comb
    begin
        pm = IN_BITS'(prime_p & ((IN_BITS'(1) << PB) - IN_BITS'(1)));
        qm = IN_BITS'(prime_q & ((IN_BITS'(1) << PB) - IN_BITS'(1)));
        pm1 = (p_reg == '0) ? '0 : p_reg - IN_BITS'(1);
        qm1 = (q_reg == '0) ? '0 : q_reg - IN_BITS'(1);
        prod = mstep_reg ? pm1 * qm1 : p_reg * q_reg;
        trial = {rem_reg, dvd_reg[KEY_BITS-1]} - {1'b0, dvs_reg};
    end

    assign status.div_done = div_done_reg;
    assign status.r1_zero  = (r1_reg == '0);
    assign status.m_zero   = (m_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mstep_reg    <= 1'b0;
            div_done_reg <= 1'b0;
            cnt_reg      <= '0;
            ok_reg       <= 1'b0;
            fix_reg      <= 1'b0;
        end
        else
        begin
            div_done_reg <= 1'b0;
            unique case (cmd.code)
                CMD_LOAD:
                begin
                    p_reg     <= pm;
                    q_reg     <= qm;
                    r1_reg    <= public_exp;
                    mstep_reg <= 1'b0;
                    fix_reg   <= 1'b0;
                end
                CMD_MUL:
                begin
                    if (!mstep_reg)
                    begin
                        n_reg     <= KEY_BITS'(prod);
                        mstep_reg <= 1'b1;
                    end
                    else
                    begin
                        m_reg    <= KEY_BITS'(prod);
                        // first division reduces e mod m
                        r0_reg   <= KEY_BITS'(prod);
                        mag0_reg <= '0;
                        mag1_reg <= KEY_BITS'(1);
                        neg0_reg <= 1'b0;
                        neg1_reg <= 1'b0;
                    end
                end
                CMD_DIV_START:
                begin
                    // e mod m first, then r0 / r1; fix pass: mag0 mod m
                    if (fix_reg)
                    begin
                        dvd_reg <= mag0_reg;
                        dvs_reg <= m_reg;
                    end
                    else if (mstep_reg)
                    begin
                        dvd_reg <= r1_reg;
                        dvs_reg <= r0_reg;
                    end
                    else
                    begin
                        dvd_reg <= r0_reg;
                        dvs_reg <= r1_reg;
                    end
                    rem_reg <= '0;
                    acc_reg <= '0;
                    cnt_reg <= '0;
                end
                CMD_DIV_STEP:
                begin
                    if (!trial[KEY_BITS])
                    begin
                        rem_reg <= trial[KEY_BITS-1:0];
                        acc_reg <= {acc_reg[KEY_BITS-2:0], 1'b0} + mag1_reg;
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[KEY_BITS-2:0], dvd_reg[KEY_BITS-1]};
                        acc_reg <= {acc_reg[KEY_BITS-2:0], 1'b0};
                    end
                    dvd_reg <= {dvd_reg[KEY_BITS-2:0], 1'b0};
                    cnt_reg <= cnt_reg + CNT_BITS'(1);
                    if (cnt_reg == CNT_BITS'(KEY_BITS-1))
                        div_done_reg <= 1'b1;
                end
                CMD_EUCLID:
                begin
                    if (mstep_reg)
                    begin
                        // result of e mod m
                        r1_reg    <= rem_reg;
                        mstep_reg <= 1'b0;
                    end
                    else
                    begin
                        r0_reg   <= r1_reg;
                        r1_reg   <= rem_reg;
                        mag0_reg <= mag1_reg;
                        mag1_reg <= mag0_reg + acc_reg;
                        neg0_reg <= neg1_reg;
                        neg1_reg <= !neg1_reg;
                    end
                end
                CMD_FIX:
                begin
                    if (!fix_reg)
                    begin
                        fix_reg <= 1'b1;
                        ok_reg  <= (r0_reg == KEY_BITS'(1)) && (m_reg != '0);
                    end
                    else
                    begin
                        if (!ok_reg)
                            d_reg <= '0;
                        else if (neg0_reg && rem_reg != '0)
                            d_reg <= m_reg - rem_reg;
                        else
                            d_reg <= rem_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign n_out  = n_reg;
    assign m_out  = m_reg;
    assign d_out  = d_reg;
    assign ok_out = ok_reg;
endmodule

/* hw/rtl/rsa_ctrl.sv */
// Controller: sequences load, products, divisions and Euclid steps.
module rsa_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  rsa_pkg::dp_status_t status,
    output rsa_pkg::dp_cmd_t    cmd
);
    import rsa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_CHK, S_DSTART, S_DSTEP, S_UPD,
        S_TEST, S_FIX0, S_FSTART, S_FSTEP, S_FIX1, S_DONE
    } state_t;

    state_t state_reg, state_next;
    cmd_code_t code;

    always_comb
    begin
        state_next = state_reg;
        code       = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    code       = CMD_LOAD;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                code       = CMD_MUL;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                code       = CMD_MUL;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (status.m_zero)
                    state_next = S_FIX0;
                else
                    state_next = S_DSTART;
            end
            S_DSTART:
            begin
                code       = CMD_DIV_START;
                state_next = S_DSTEP;
            end
            S_DSTEP:
            begin
                code = CMD_DIV_STEP;
                if (status.div_done)
                begin
                    code       = CMD_EUCLID;
                    state_next = S_TEST;
                end
            end
            S_UPD:    state_next = S_TEST;
            S_TEST:
            begin
                if (status.r1_zero)
                    state_next = S_FIX0;
                else
                    state_next = S_DSTART;
            end
            S_FIX0:
            begin
                code       = CMD_FIX;
                state_next = S_FSTART;
            end
            S_FSTART:
            begin
                code       = CMD_DIV_START;
                state_next = S_FSTEP;
            end
            S_FSTEP:
            begin
                code = CMD_DIV_STEP;
                if (status.div_done)
                begin
                    code       = CMD_FIX;
                    state_next = S_DONE;
                end
            end
            S_FIX1:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_DONE);
    assign cmd.code  = code;
endmodule

/* hw/rtl/rsa_private_exponent.sv */
// Top level of the RSA private exponent derivation block.
//   channel | dir | words
//   in      | in  | prime_p, prime_q, public_exp
//   out     | out | modulus_n, totient_m, private_exp, key_valid
// One key at a time: accept, two multiplies and a totient check, then per
// division a start, one step per quotient bit, an update and a test: one for
// e mod m, one per Euclid step, one for the final reduction of the coefficient.
// A zero totient goes from the check straight to the final reduction.
// Reset clears the controller; the result holds until out.ready.
module rsa_private_exponent #(
    parameter int PRIME_BITS = rsa_pkg::PRIME_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    rsa_in_if.sink    in,
    rsa_out_if.source out
);
    import rsa_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    rsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rsa_datapath #(.PRIME_BITS(PRIME_BITS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .prime_p    (in.prime_p),
        .prime_q    (in.prime_q),
        .public_exp (in.public_exp),
        .status     (status),
        .n_out      (out.modulus_n),
        .m_out      (out.totient_m),
        .d_out      (out.private_exp),
        .ok_out     (out.key_valid)
    );
endmodule

/* hw/rtl/rsa_checker.sv */
// Port-level checker for the RSA private exponent block, bound to the top.
module rsa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [35:0] totient_m,
    input logic [35:0] private_exp,
    input logic        key_valid
);
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("accepting while result pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(private_exp))
        else $error("result dropped");
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !key_valid |-> private_exp == '0) else $error("d not zero");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_valid && totient_m > 36'd1 |-> private_exp < totient_m)
        else $error("d out of range");
endmodule

bind rsa_private_exponent rsa_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in.valid),
    .in_ready    (in.ready),
    .out_valid   (out.valid),
    .out_ready   (out.ready),
    .totient_m   (out.totient_m),
    .private_exp (out.private_exp),
    .key_valid   (out.key_valid)
);
